// File: rtl/ttb_pkg.sv
`default_nettype none

package ttb_pkg;

  localparam int TILE_PIXELS_D       = 16;
  localparam int TILE_CAPACITY_D     = 1024;
  localparam int BIN_CAPACITY_D      = 8192;
  localparam int TRIANGLE_CAPACITY_D = 1024;

  localparam int COORD_W     = 12;
  localparam int GRID_W      = 11;
  localparam int QIDX_W      = 13;
  localparam int START_OUT_W = 14;
  localparam int COUNT_OUT_W = 11;
  localparam int ID_OUT_W    = 10;
  localparam int TILE_IDX_W  = 23;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_TILE = 2'd1;
  localparam logic [1:0] KIND_BIN  = 2'd2;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [GRID_W-1:0] GRID_RESET = 11'd32;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } box_t;

  typedef struct packed {
    logic                  run;
    logic                  hit;
    logic [TILE_IDX_W-1:0] tile;
  } walk_stat_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ttb_ram.sv
`default_nettype none

module ttb_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  localparam int AW = ttb_pkg::addr_w(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/ttb_tile_walker.sv
`default_nettype none

module ttb_tile_walker #(
  parameter int TILE_PIXELS = ttb_pkg::TILE_PIXELS_D
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              load,
  input  wire ttb_pkg::box_t                     box,
  input  wire logic [ttb_pkg::GRID_W-1:0]        grid_w,
  input  wire logic [ttb_pkg::GRID_W-1:0]        grid_h,
  input  wire logic [ttb_pkg::TILE_IDX_W-1:0]    tiles_n,
  input  wire logic                              adv,
  output ttb_pkg::walk_stat_t                    stat,
  output logic                                   idle
);

  localparam int GW  = ttb_pkg::GRID_W;
  localparam int TW  = ttb_pkg::TILE_IDX_W;
  localparam int DSH = $clog2(TILE_PIXELS);
  localparam int SH  = ttb_pkg::COORD_W + DSH;
  localparam int PW  = ttb_pkg::COORD_W + SH;
  localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / TILE_PIXELS + 64'd1);

  typedef enum logic [1:0] {W_IDLE, W_SETUP, W_RUN} wstate_t;

  wstate_t       state_r;
  logic [GW-1:0] x0_r, y0_r, x1_r, y1_r, x_r, y_r;
  logic [TW-1:0] row_r;
  logic [GW-1:0] x1c, y1c;
  logic          empty;
  logic [TW-1:0] tile;
  logic          past;

  // Exact quotient by the tile size through a rounded-up reciprocal.
  function automatic logic [GW-1:0] tdiv(input logic [ttb_pkg::COORD_W-1:0] v);
    logic [PW-1:0] p;
    p = PW'(v) * PW'(RECIP);
    return p[SH +: GW];
  endfunction

  always_comb begin
    x1c   = (x1_r >= grid_w) ? grid_w - GW'(1) : x1_r;
    y1c   = (y1_r >= grid_h) ? grid_h - GW'(1) : y1_r;
    empty = (grid_w == '0) || (grid_h == '0) || (x0_r > x1c) || (y0_r > y1c);
    tile  = row_r + TW'(x_r);
    past  = row_r >= tiles_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
    end else begin
      unique case (state_r)
        W_IDLE: begin
          if (load) begin
            x0_r    <= tdiv(box.left);
            y0_r    <= tdiv(box.top);
            x1_r    <= tdiv(box.right);
            y1_r    <= tdiv(box.bottom);
            state_r <= W_SETUP;
          end
        end
        W_SETUP: begin
          x1_r    <= x1c;
          y1_r    <= y1c;
          x_r     <= x0_r;
          y_r     <= y0_r;
          row_r   <= TW'(y0_r) * TW'(grid_w);
          state_r <= empty ? W_IDLE : W_RUN;
        end
        W_RUN: begin
          if (past) begin
            state_r <= W_IDLE;
          end else if (adv) begin
            if (x_r == x1_r) begin
              if (y_r == y1_r) begin
                state_r <= W_IDLE;
              end else begin
                y_r   <= y_r + GW'(1);
                x_r   <= x0_r;
                row_r <= row_r + TW'(grid_w);
              end
            end else begin
              x_r <= x_r + GW'(1);
            end
          end
        end
        default: state_r <= W_IDLE;
      endcase
    end
  end

  assign stat.run  = (state_r == W_RUN) && !past;
  assign stat.hit  = tile < tiles_n;
  assign stat.tile = tile;
  assign idle      = state_r == W_IDLE;

endmodule

`default_nettype wire

// File: rtl/triangle_tile_binner_unit.sv
// Channel   Ports                          Handshake
// input     start, busy, in_*              taken when start is high and busy low
// result    out_valid, out_*               one cycle per item, no stall
// config    cfg_we, cfg_index, cfg_wdata   written when cfg_we is high
//
// Non-final loads and queries leave busy low, so another item can follow them; a query answers
// in the next cycle. A final load runs the passes in order: a count clear, a counting walk over
// the triangles, a prefix pass over the grid tiles, a second count clear and a scatter walk;
// each covered tile gets a count memory read and then a write (in the scatter walk, only while
// its bin position is below BIN_CAPACITY). After reset, a clearing pass over all TILE_CAPACITY
// count entries holds busy high. The result receiver cannot stall the block.
`default_nettype none

module triangle_tile_binner_unit #(
  parameter int TILE_PIXELS       = ttb_pkg::TILE_PIXELS_D,
  parameter int TILE_CAPACITY     = ttb_pkg::TILE_CAPACITY_D,
  parameter int BIN_CAPACITY      = ttb_pkg::BIN_CAPACITY_D,
  parameter int TRIANGLE_CAPACITY = ttb_pkg::TRIANGLE_CAPACITY_D
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          in_kind,
  input  wire logic [ttb_pkg::COORD_W-1:0]         in_box_left,
  input  wire logic [ttb_pkg::COORD_W-1:0]         in_box_top,
  input  wire logic [ttb_pkg::COORD_W-1:0]         in_box_right,
  input  wire logic [ttb_pkg::COORD_W-1:0]         in_box_bottom,
  input  wire logic                                in_final_item,
  input  wire logic [ttb_pkg::QIDX_W-1:0]          in_query_index,
  output logic                                     out_valid,
  output logic [ttb_pkg::START_OUT_W-1:0]          out_tile_first_entry,
  output logic [ttb_pkg::COUNT_OUT_W-1:0]          out_tile_entry_count,
  output logic [ttb_pkg::ID_OUT_W-1:0]             out_triangle_id,
  output logic [ttb_pkg::START_OUT_W-1:0]          out_total_entries,
  output logic                                     out_truncated,
  output logic                                     out_bad_query,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic [ttb_pkg::GRID_W-1:0]          cfg_wdata
);

  localparam int TAW  = ttb_pkg::addr_w(TILE_CAPACITY);
  localparam int BAW  = ttb_pkg::addr_w(BIN_CAPACITY);
  localparam int TRAW = ttb_pkg::addr_w(TRIANGLE_CAPACITY);
  localparam int LW   = $clog2(TRIANGLE_CAPACITY + 1);
  localparam int CW   = LW;
  localparam int STW  = $clog2(BIN_CAPACITY + 1);
  localparam int NW   = $clog2(TILE_CAPACITY + 1);
  localparam int SUMW = ((STW > CW) ? STW : CW) + 1;
  localparam int TW   = ttb_pkg::TILE_IDX_W;
  localparam int GW   = ttb_pkg::GRID_W;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_TRI_RD, S_TRI_LD, S_WALK, S_PFX, S_RESULT
  } state_t;
  typedef enum logic [1:0] {P_INIT, P_COUNT, P_SCAT} pass_t;
  typedef enum logic [1:0] {RK_TILE, RK_BIN, RK_FINAL} rkind_t;

  state_t         state_r;
  pass_t          pass_r;
  rkind_t         o_kind_r;
  logic           o_vld_r, o_bad_r;
  logic [GW-1:0]  grid_w_r, grid_h_r;
  logic [LW-1:0]  loaded_r;
  logic [TRAW-1:0] t_r;
  logic [TAW-1:0] clr_r;
  logic [NW-1:0]  pi_r;
  logic [TAW-1:0] pidx_r;
  logic           pv_r;
  logic [STW-1:0] total_r, entry_total_r;
  logic           sat_r, ovf_r, ph_r;

  logic           accept, ld_acc, has_room, pfx_issue, tri_last, clr_last;
  logic [31:0]    qx;
  logic [2*GW-1:0] wh;
  logic [TW-1:0]  tiles_n;
  logic [SUMW-1:0] sum, pos;

  ttb_pkg::box_t       box_in, box_rd;
  ttb_pkg::walk_stat_t stat;
  logic                walk_idle, adv;

  logic            cnt_we;
  logic [TAW-1:0]  cnt_waddr, cnt_raddr, st_raddr;
  logic [CW-1:0]   cnt_wdata, cnt_rd;
  logic [STW-1:0]  st_rd, st_wdata;
  logic            bin_we;
  logic [TRAW-1:0] bin_rd;

  assign busy     = state_r != S_IDLE;
  assign accept   = start && !busy;
  assign ld_acc   = accept && (in_kind == ttb_pkg::KIND_LOAD);
  assign has_room = loaded_r < LW'(TRIANGLE_CAPACITY);
  assign qx       = 32'(in_query_index);
  assign wh       = (2*GW)'(grid_w_r) * (2*GW)'(grid_h_r);
  assign tiles_n  = (TW'(wh) > TW'(TILE_CAPACITY)) ? TW'(TILE_CAPACITY) : TW'(wh);
  assign pfx_issue = TW'(pi_r) < tiles_n;
  assign tri_last = (LW'(t_r) + LW'(1)) == loaded_r;
  assign clr_last = clr_r == TAW'(TILE_CAPACITY - 1);
  assign sum      = SUMW'(total_r) + SUMW'(cnt_rd);
  assign pos      = SUMW'(st_rd) + SUMW'(cnt_rd);

  assign box_in.left   = in_box_left;
  assign box_in.top    = in_box_top;
  assign box_in.right  = in_box_right;
  assign box_in.bottom = in_box_bottom;

  ttb_ram #(.DEPTH(TRIANGLE_CAPACITY), .WIDTH($bits(ttb_pkg::box_t))) u_box_ram (
    .clk   (clk),
    .we    (ld_acc && has_room),
    .waddr (loaded_r[TRAW-1:0]),
    .wdata (box_in),
    .raddr (t_r),
    .rdata (box_rd)
  );

  ttb_tile_walker #(.TILE_PIXELS(TILE_PIXELS)) u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (state_r == S_TRI_LD),
    .box     (box_rd),
    .grid_w  (grid_w_r),
    .grid_h  (grid_h_r),
    .tiles_n (tiles_n),
    .adv     (adv),
    .stat    (stat),
    .idle    (walk_idle)
  );

  ttb_ram #(.DEPTH(TILE_CAPACITY), .WIDTH(CW)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  ttb_ram #(.DEPTH(TILE_CAPACITY), .WIDTH(STW)) u_start_ram (
    .clk   (clk),
    .we    (state_r == S_PFX && pv_r),
    .waddr (pidx_r),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rd)
  );

  ttb_ram #(.DEPTH(BIN_CAPACITY), .WIDTH(TRAW)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (pos[BAW-1:0]),
    .wdata (t_r),
    .raddr (BAW'(in_query_index)),
    .rdata (bin_rd)
  );

  assign st_wdata = sat_r ? STW'(BIN_CAPACITY) : total_r;

  always_comb begin
    cnt_raddr = stat.tile[TAW-1:0];
    st_raddr  = stat.tile[TAW-1:0];
    if (state_r == S_IDLE) begin
      cnt_raddr = TAW'(in_query_index);
      st_raddr  = TAW'(in_query_index);
    end else if (state_r == S_PFX) begin
      cnt_raddr = pi_r[TAW-1:0];
    end
  end

  always_comb begin
    adv       = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = stat.tile[TAW-1:0];
    cnt_wdata = cnt_rd + CW'(1);
    bin_we    = 1'b0;
    if (state_r == S_CLR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_r;
      cnt_wdata = '0;
    end else if (state_r == S_WALK) begin
      if (ph_r) begin
        adv = 1'b1;
        if (pass_r != P_SCAT) begin
          cnt_we = 1'b1;
        end else if (pos < SUMW'(BIN_CAPACITY)) begin
          cnt_we = 1'b1;
          bin_we = 1'b1;
        end
      end else if (stat.run && !stat.hit) begin
        adv = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      pass_r        <= P_INIT;
      clr_r         <= '0;
      grid_w_r      <= ttb_pkg::GRID_RESET;
      grid_h_r      <= ttb_pkg::GRID_RESET;
      loaded_r      <= '0;
      t_r           <= '0;
      pi_r          <= '0;
      pv_r          <= 1'b0;
      ph_r          <= 1'b0;
      total_r       <= '0;
      sat_r         <= 1'b0;
      entry_total_r <= '0;
      ovf_r         <= 1'b0;
      o_vld_r       <= 1'b0;
      o_kind_r      <= RK_TILE;
      o_bad_r       <= 1'b0;
    end else begin
      o_vld_r <= 1'b0;
      ph_r    <= (state_r == S_WALK) && stat.run && stat.hit && !ph_r;
      if (cfg_we) begin
        if (cfg_index == ttb_pkg::REG_GRID_WIDTH) begin
          grid_w_r <= cfg_wdata;
        end else begin
          grid_h_r <= cfg_wdata;
        end
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + TAW'(1);
          if (clr_last) begin
            t_r <= '0;
            state_r <= (pass_r == P_INIT) ? S_IDLE : S_TRI_RD;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (in_kind)
              ttb_pkg::KIND_LOAD: begin
                ovf_r <= ((loaded_r == '0) ? 1'b0 : ovf_r) | !has_room;
                if (has_room) begin
                  loaded_r <= loaded_r + LW'(1);
                end
                if (in_final_item) begin
                  pass_r  <= P_COUNT;
                  clr_r   <= '0;
                  state_r <= S_CLR;
                end
              end
              ttb_pkg::KIND_TILE: begin
                o_vld_r  <= 1'b1;
                o_kind_r <= RK_TILE;
                o_bad_r  <= !(qx < 32'(tiles_n));
              end
              ttb_pkg::KIND_BIN: begin
                o_vld_r  <= 1'b1;
                o_kind_r <= RK_BIN;
                o_bad_r  <= !(qx < 32'(entry_total_r) && qx < 32'(BIN_CAPACITY));
              end
              default: ;
            endcase
          end
        end
        S_TRI_RD: state_r <= S_TRI_LD;
        S_TRI_LD: state_r <= S_WALK;
        S_WALK: begin
          if (walk_idle && !ph_r) begin
            if (tri_last) begin
              if (pass_r == P_SCAT) begin
                state_r <= S_RESULT;
              end else begin
                pi_r    <= '0;
                pv_r    <= 1'b0;
                total_r <= '0;
                sat_r   <= 1'b0;
                state_r <= S_PFX;
              end
            end else begin
              t_r     <= t_r + TRAW'(1);
              state_r <= S_TRI_RD;
            end
          end
        end
        S_PFX: begin
          pv_r   <= pfx_issue;
          pidx_r <= pi_r[TAW-1:0];
          if (pfx_issue) begin
            pi_r <= pi_r + NW'(1);
          end
          if (pv_r && !sat_r) begin
            if (sum > SUMW'(BIN_CAPACITY)) begin
              total_r <= STW'(BIN_CAPACITY);
              sat_r   <= 1'b1;
            end else begin
              total_r <= STW'(sum);
            end
          end
          if (!pfx_issue && !pv_r) begin
            entry_total_r <= total_r;
            ovf_r   <= ovf_r | sat_r;
            pass_r  <= P_SCAT;
            clr_r   <= '0;
            state_r <= S_CLR;
          end
        end
        S_RESULT: begin
          o_vld_r  <= 1'b1;
          o_kind_r <= RK_FINAL;
          o_bad_r  <= 1'b0;
          loaded_r <= '0;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = o_vld_r;
  assign out_tile_first_entry = (o_kind_r == RK_TILE && !o_bad_r) ?
                                ttb_pkg::START_OUT_W'(st_rd) : '0;
  assign out_tile_entry_count = (o_kind_r == RK_TILE && !o_bad_r) ?
                                ttb_pkg::COUNT_OUT_W'(cnt_rd) : '0;
  assign out_triangle_id      = (o_kind_r == RK_BIN && !o_bad_r) ?
                                ttb_pkg::ID_OUT_W'(bin_rd) : '0;
  assign out_total_entries    = ttb_pkg::START_OUT_W'(entry_total_r);
  assign out_truncated        = ovf_r;
  assign out_bad_query        = o_bad_r;

  a_result_after_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT) |=> (out_valid && o_kind_r == RK_FINAL))
    else $error("final item result missing after the passes");

  a_final_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_acc && in_final_item) |=> busy)
    else $error("final load did not start the passes");

  a_phase_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r |-> (state_r == S_WALK))
    else $error("tile update pending outside a walk");

  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (SUMW'(entry_total_r) <= SUMW'(BIN_CAPACITY)) && (SUMW'(total_r) <= SUMW'(BIN_CAPACITY)))
    else $error("entry total above bin capacity");

endmodule

`default_nettype wire

// File: verif/tb_triangle_tile_binner_unit.sv
`timescale 1ns / 100ps

module tb_triangle_tile_binner_unit;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int TRI_CAP = ttb_pkg::TRIANGLE_CAPACITY_D;
  localparam int TILE_CAP = ttb_pkg::TILE_CAPACITY_D;
  localparam int BIN_CAP = ttb_pkg::BIN_CAPACITY_D;
  localparam int CYCLE_LIMIT = 10000000;

  typedef struct {
    bit is_cfg;
    logic cfg_reg;
    logic [ttb_pkg::GRID_W-1:0] cfg_val;
    logic [1:0] kind;
    ttb_pkg::box_t box;
    logic fin;
    logic [ttb_pkg::QIDX_W-1:0] qidx;
  } bin_item_t;

  typedef struct {
    logic [ttb_pkg::START_OUT_W-1:0] first;
    logic [ttb_pkg::COUNT_OUT_W-1:0] cnt;
    logic [ttb_pkg::ID_OUT_W-1:0] tri_id;
    logic [ttb_pkg::START_OUT_W-1:0] total;
    logic trunc;
    logic bad;
  } bin_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = '0;
  logic [ttb_pkg::COORD_W-1:0] in_box_left = '0;
  logic [ttb_pkg::COORD_W-1:0] in_box_top = '0;
  logic [ttb_pkg::COORD_W-1:0] in_box_right = '0;
  logic [ttb_pkg::COORD_W-1:0] in_box_bottom = '0;
  logic in_final_item = 1'b0;
  logic [ttb_pkg::QIDX_W-1:0] in_query_index = '0;
  logic out_valid;
  logic [ttb_pkg::START_OUT_W-1:0] out_tile_first_entry;
  logic [ttb_pkg::COUNT_OUT_W-1:0] out_tile_entry_count;
  logic [ttb_pkg::ID_OUT_W-1:0] out_triangle_id;
  logic [ttb_pkg::START_OUT_W-1:0] out_total_entries;
  logic out_truncated;
  logic out_bad_query;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [ttb_pkg::GRID_W-1:0] cfg_wdata = '0;

  triangle_tile_binner_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_box_left(in_box_left), .in_box_top(in_box_top),
    .in_box_right(in_box_right), .in_box_bottom(in_box_bottom),
    .in_final_item(in_final_item), .in_query_index(in_query_index),
    .out_valid(out_valid), .out_tile_first_entry(out_tile_first_entry),
    .out_tile_entry_count(out_tile_entry_count), .out_triangle_id(out_triangle_id),
    .out_total_entries(out_total_entries), .out_truncated(out_truncated),
    .out_bad_query(out_bad_query),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the binner state.
  int grid_w = 32;
  int grid_h = 32;
  ttb_pkg::box_t tri_boxes [TRI_CAP];
  int loaded_cnt = 0;
  int tile_counts [TILE_CAP];
  int tile_starts [TILE_CAP];
  logic [ttb_pkg::ID_OUT_W-1:0] bin_ids [BIN_CAP];
  int entry_total = 0;
  bit overflow = 1'b0;

  bin_item_t pending_items [$];
  bin_answer_t expected_answers [$];
  int err_count = 0;
  int cycle_count = 0;

  function automatic int tiles_used(input int w, input int h);
    int n;
    n = w * h;
    return (n > TILE_CAP) ? TILE_CAP : n;
  endfunction

  task automatic walk_box(input int t, input bit scatter);
    int n, x0, y0, x1, y1, x, y, tile, pos;
    n = tiles_used(grid_w, grid_h);
    if (grid_w == 0 || grid_h == 0) return;
    x0 = int'(tri_boxes[t].left) / ttb_pkg::TILE_PIXELS_D;
    y0 = int'(tri_boxes[t].top) / ttb_pkg::TILE_PIXELS_D;
    x1 = int'(tri_boxes[t].right) / ttb_pkg::TILE_PIXELS_D;
    y1 = int'(tri_boxes[t].bottom) / ttb_pkg::TILE_PIXELS_D;
    if (x1 >= grid_w) x1 = grid_w - 1;
    if (y1 >= grid_h) y1 = grid_h - 1;
    for (y = y0; y <= y1; y++) begin
      for (x = x0; x <= x1; x++) begin
        tile = y * grid_w + x;
        if (tile < n) begin
          if (!scatter) begin
            tile_counts[tile]++;
          end else begin
            pos = tile_starts[tile] + tile_counts[tile];
            if (pos < BIN_CAP) begin
              bin_ids[pos] = t[ttb_pkg::ID_OUT_W-1:0];
              tile_counts[tile]++;
            end
          end
        end
      end
    end
  endtask

  task automatic run_binning();
    int n, i, t, sum;
    bit sat;
    n = tiles_used(grid_w, grid_h);
    sum = 0;
    sat = 1'b0;
    foreach (tile_counts[i]) tile_counts[i] = 0;
    for (t = 0; t < loaded_cnt; t++) walk_box(t, 1'b0);
    for (i = 0; i < n; i++) begin
      if (sat) begin
        tile_starts[i] = BIN_CAP;
      end else begin
        tile_starts[i] = sum;
        sum += tile_counts[i];
        if (sum > BIN_CAP) begin
          sum = BIN_CAP;
          sat = 1'b1;
        end
      end
    end
    entry_total = sum;
    if (sat) overflow = 1'b1;
    foreach (tile_counts[i]) tile_counts[i] = 0;
    for (t = 0; t < loaded_cnt; t++) walk_box(t, 1'b1);
  endtask

  task automatic predict_item(input bin_item_t it);
    bin_answer_t a;
    int q;
    a = '{default: '0};
    q = int'(it.qidx);
    case (it.kind)
      ttb_pkg::KIND_LOAD: begin
        if (loaded_cnt == 0) overflow = 1'b0;
        if (loaded_cnt < TRI_CAP) begin
          tri_boxes[loaded_cnt] = it.box;
          loaded_cnt++;
        end else begin
          overflow = 1'b1;
        end
        if (!it.fin) return;
        run_binning();
        loaded_cnt = 0;
      end
      ttb_pkg::KIND_TILE: begin
        if (q < tiles_used(grid_w, grid_h)) begin
          a.first = ttb_pkg::START_OUT_W'(tile_starts[q]);
          a.cnt = ttb_pkg::COUNT_OUT_W'(tile_counts[q]);
        end else begin
          a.bad = 1'b1;
        end
      end
      ttb_pkg::KIND_BIN: begin
        if (q < entry_total && q < BIN_CAP) a.tri_id = bin_ids[q];
        else a.bad = 1'b1;
      end
      default: return;
    endcase
    a.total = ttb_pkg::START_OUT_W'(entry_total);
    a.trunc = overflow;
    expected_answers.push_back(a);
  endtask

  // Stimulus generation keeps its own view of the grid and of which tile starts exist.
  int gen_w = 32;
  int gen_h = 32;
  bit gen_start_written [TILE_CAP];
  int gen_items = 0;

  task automatic add_cfg(input logic r, input int v);
    bin_item_t it;
    it = '{default: '0};
    it.is_cfg = 1'b1;
    it.cfg_reg = r;
    it.cfg_val = ttb_pkg::GRID_W'(v);
    if (r == ttb_pkg::REG_GRID_WIDTH) gen_w = v;
    else gen_h = v;
    pending_items.push_back(it);
  endtask

  task automatic add_load(input int l, input int t, input int r, input int b, input bit fin);
    bin_item_t it;
    int i;
    it = '{default: '0};
    it.kind = ttb_pkg::KIND_LOAD;
    it.box = '{left: ttb_pkg::COORD_W'(l), top: ttb_pkg::COORD_W'(t),
               right: ttb_pkg::COORD_W'(r), bottom: ttb_pkg::COORD_W'(b)};
    it.fin = fin;
    it.qidx = ttb_pkg::QIDX_W'($urandom);
    if (fin) begin
      for (i = 0; i < tiles_used(gen_w, gen_h); i++) gen_start_written[i] = 1'b1;
    end
    pending_items.push_back(it);
    gen_items++;
  endtask

  task automatic add_query(input logic [1:0] k, input int q);
    bin_item_t it;
    int qi;
    it = '{default: '0};
    it.kind = k;
    it.qidx = ttb_pkg::QIDX_W'(q);
    it.fin = 1'($urandom);
    it.box = ttb_pkg::box_t'(48'({$urandom, $urandom}));
    qi = int'(it.qidx);
    // A tile whose start was never formed must not be read.
    if (k == ttb_pkg::KIND_TILE && qi < tiles_used(gen_w, gen_h) && !gen_start_written[qi])
      it.qidx = ttb_pkg::QIDX_W'(tiles_used(gen_w, gen_h));
    pending_items.push_back(it);
    gen_items++;
  endtask

  task automatic add_random_frame(input bit allow_huge);
    int nl, i, l, t, r, b, sel;
    nl = $urandom_range(1, 12);
    for (i = 0; i < nl; i++) begin
      sel = $urandom_range(0, 9);
      l = $urandom_range(0, 4095);
      t = $urandom_range(0, 4095);
      if (sel == 0 && allow_huge) begin
        r = $urandom_range(0, 4095);
        b = $urandom_range(0, 4095);
      end else if (sel == 1) begin
        r = $urandom_range(0, l);
        b = $urandom_range(0, 4095);
      end else begin
        if (sel == 2) begin
          l = $urandom_range(0, 40);
          t = $urandom_range(0, 40);
        end
        r = l + $urandom_range(0, 63);
        b = t + $urandom_range(0, 63);
        if (r > 4095) r = 4095;
        if (b > 4095) b = 4095;
      end
      add_load(l, t, r, b, i == nl - 1);
      if ($urandom_range(0, 15) == 0) add_query(KIND_NONE, $urandom);
    end
    for (i = $urandom_range(4, 16); i > 0; i--) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        add_query(ttb_pkg::KIND_TILE, $urandom_range(0, tiles_used(gen_w, gen_h) + 2));
      end else if (sel < 8) begin
        add_query(ttb_pkg::KIND_BIN, $urandom_range(0, 80));
      end else if (sel == 8) begin
        add_query(KIND_NONE, $urandom);
      end else begin
        add_query(2'($urandom_range(1, 2)), $urandom);
      end
    end
  endtask

  // Driver.
  bin_item_t cur_item;
  bit holding = 1'b0;
  bit steady = 1'b0;
  int gap_left = 0;
  int settle = 0;
  bit drive_done = 1'b0;

  always @(posedge clk) begin
    bit nxt_start, nxt_we;
    nxt_start = 1'b0;
    nxt_we = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        predict_item(cur_item);
        holding = 1'b0;
      end
      if (holding) begin
        nxt_start = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        if ($urandom_range(0, 39) == 0) steady = !steady;
        if (pending_items[0].is_cfg) begin
          if (expected_answers.size() == 0 && !busy && !start) settle++;
          else settle = 0;
          if (settle >= 8) begin
            cur_item = pending_items.pop_front();
            cfg_index <= cur_item.cfg_reg;
            cfg_wdata <= cur_item.cfg_val;
            nxt_we = 1'b1;
            if (cur_item.cfg_reg == ttb_pkg::REG_GRID_WIDTH) grid_w = int'(cur_item.cfg_val);
            else grid_h = int'(cur_item.cfg_val);
            settle = 0;
          end
        end else begin
          cur_item = pending_items.pop_front();
          in_kind <= cur_item.kind;
          in_box_left <= cur_item.box.left;
          in_box_top <= cur_item.box.top;
          in_box_right <= cur_item.box.right;
          in_box_bottom <= cur_item.box.bottom;
          in_final_item <= cur_item.fin;
          in_query_index <= cur_item.qidx;
          holding = 1'b1;
          nxt_start = 1'b1;
          gap_left = steady ? 0 : $urandom_range(0, 9);
        end
      end else begin
        drive_done = 1'b1;
      end
    end
    start <= nxt_start;
    cfg_we <= nxt_we;
  end

  task automatic report(input string field, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, field, got, want);
    err_count++;
  endtask

  // Monitor.
  always @(posedge clk) begin
    bin_answer_t a;
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        report("out_valid", 1, 0);
      end else begin
        a = expected_answers.pop_front();
        if (out_tile_first_entry !== a.first)
          report("tile_first_entry", int'(out_tile_first_entry), int'(a.first));
        if (out_tile_entry_count !== a.cnt)
          report("tile_entry_count", int'(out_tile_entry_count), int'(a.cnt));
        if (out_triangle_id !== a.tri_id)
          report("triangle_id", int'(out_triangle_id), int'(a.tri_id));
        if (out_total_entries !== a.total)
          report("total_entries", int'(out_total_entries), int'(a.total));
        if (out_truncated !== a.trunc)
          report("truncated", int'(out_truncated), int'(a.trunc));
        if (out_bad_query !== a.bad)
          report("bad_query", int'(out_bad_query), int'(a.bad));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("triangle_tile_binner_unit verification failed");
      $finish;
    end
  end

  int grid_settings [10][2] = '{'{32, 32}, '{1, 1}, '{1024, 1}, '{1, 1024}, '{1024, 1024},
                                '{0, 5}, '{5, 0}, '{2047, 2047}, '{7, 3}, '{32, 32}};

  initial begin
    int ph, i;
    // Directed part.
    add_query(ttb_pkg::KIND_BIN, 0);
    add_load(0, 0, 4095, 4095, 1'b1);
    add_query(ttb_pkg::KIND_TILE, 0);
    add_query(ttb_pkg::KIND_TILE, 1023);
    add_query(ttb_pkg::KIND_TILE, 1024);
    add_query(ttb_pkg::KIND_TILE, 8191);
    add_query(ttb_pkg::KIND_BIN, 0);
    add_query(ttb_pkg::KIND_BIN, 1023);
    add_query(ttb_pkg::KIND_BIN, 1024);
    add_query(ttb_pkg::KIND_BIN, 8191);
    add_load(100, 100, 50, 50, 1'b0);
    add_load(15, 15, 16, 16, 1'b0);
    add_load(4095, 4095, 4095, 4095, 1'b1);
    add_query(KIND_NONE, 5);
    add_query(ttb_pkg::KIND_TILE, 17);
    add_query(ttb_pkg::KIND_BIN, 1);
    // Bin capacity saturates with nine full-screen boxes.
    for (i = 0; i < 9; i++) add_load(0, 0, 4095, 4095, i == 8);
    add_query(ttb_pkg::KIND_TILE, 1000);
    add_query(ttb_pkg::KIND_BIN, 8191);
    add_query(ttb_pkg::KIND_TILE, 1023);

    for (ph = 0; gen_items < 1000 || ph < 10; ph++) begin
      if (ph < 10) begin
        add_cfg(ttb_pkg::REG_GRID_WIDTH, grid_settings[ph][0]);
        add_cfg(ttb_pkg::REG_GRID_HEIGHT, grid_settings[ph][1]);
      end else begin
        add_cfg(ttb_pkg::REG_GRID_WIDTH, $urandom_range(1, 40));
        add_cfg(ttb_pkg::REG_GRID_HEIGHT, $urandom_range(1, 40));
      end
      if (ph == 1) begin
        // More triangles than the block can hold.
        for (i = 0; i < TRI_CAP + 6; i++) begin
          add_load(0, 0, $urandom_range(0, 15), 3, i == TRI_CAP + 5);
        end
        add_query(ttb_pkg::KIND_TILE, 0);
        add_query(ttb_pkg::KIND_BIN, 1023);
        add_load(1, 1, 2, 2, 1'b1);
        add_query(ttb_pkg::KIND_BIN, 0);
      end
      add_random_frame(gen_w <= 64 && gen_h <= 64);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (drive_done && expected_answers.size() == 0);
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("triangle_tile_binner_unit verification clean");
    end else begin
      $display("triangle_tile_binner_unit verification failed");
    end
    $finish;
  end

endmodule
